### rtl/gbfs_pkg.sv
package gbfs_pkg;

  // Widths of the request and result fields.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VERTEX_W = 6;

  // Request kinds. The fourth code has no meaning and is dropped.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_INIT,
    ST_MISS,
    ST_DEQ,
    ST_KEY,
    ST_ROW,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

### rtl/gbfs_ram.sv
module gbfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/graph_breadth_first_search_core.sv
// Breadth-first search engine over a directed graph held as adjacency bit rows.
// Requests arrive on the in_* channel (valid/stall) and carry a kind and two
// vertex numbers: kind 0 clears the graph, kind 1 adds the edge u to v, and
// kind 2 searches from start u until vertex v is visited or the queue is empty.
// Results leave on the out_* channel, one per visited vertex in visit order,
// with run_last set on the final one of a run. An absent start vertex gives a
// single result with missing_start and run_last set and vertex zero.
// A clear takes effect as soon as it is taken; an edge add reads, modifies
// and writes back one adjacency row. In a search, each visit reads the queue
// memory and, but for the stop vertex, then the adjacency memory and then
// enqueues one neighbor per cycle through the queue write port.
// in_stall_o is high while a request is being worked on; one request is
// handled at a time. A result sits in an output register, so a stalled
// receiver only holds the engine when the next result is ready to go out.
// Reset empties the graph at once (per-row valid flops, no clearing pass);
// the queue memory needs no initialization.
module graph_breadth_first_search_core #(
  parameter int unsigned NUM_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gbfs_pkg::KIND_W-1:0]   in_kind_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] in_vertex_u_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] in_vertex_v_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbfs_pkg::VERTEX_W-1:0] out_visit_vertex_o,
  output logic                          out_run_last_o,
  output logic                          out_missing_start_o
);

  import gbfs_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_VERTICES);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam logic [VERTEX_W:0] VTX_LIMIT = (VERTEX_W + 1)'(NUM_VERTICES);

  // Returns a row with only the bit of the given vertex set.
  function automatic logic [NUM_VERTICES-1:0] vertex_bit(input logic [IDX_W-1:0] idx);
    logic [NUM_VERTICES-1:0] b;
    b      = '0;
    b[idx] = 1'b1;
    return b;
  endfunction

  // Lowest numbered set bit, so neighbors go into the queue in ascending order.
  function automatic logic [IDX_W-1:0] first_set(input logic [NUM_VERTICES-1:0] vec);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [VERTEX_W-1:0]     u_q, u_d;
  logic [VERTEX_W-1:0]     v_q, v_d;
  logic [IDX_W-1:0]        key_q, key_d;
  logic                    last_q, last_d;
  logic [PTR_W-1:0]        head_q, head_d;
  logic [PTR_W-1:0]        tail_q, tail_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic [NUM_VERTICES-1:0] present_q, present_d;
  logic [NUM_VERTICES-1:0] row_valid_q, row_valid_d;
  logic [NUM_VERTICES-1:0] row_q, row_d;

  logic                    out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0]     out_vertex_q, out_vertex_d;
  logic                    out_last_q, out_last_d;
  logic                    out_miss_q, out_miss_d;

  // Adjacency memory ports.
  logic                    adj_we;
  logic [IDX_W-1:0]        adj_waddr;
  logic [NUM_VERTICES-1:0] adj_wdata;
  logic [IDX_W-1:0]        adj_raddr;
  logic [NUM_VERTICES-1:0] adj_rdata;

  // Pending queue memory ports.
  logic                    q_we;
  logic [IDX_W-1:0]        q_waddr;
  logic [IDX_W-1:0]        q_wdata;
  logic [IDX_W-1:0]        q_raddr;
  logic [IDX_W-1:0]        q_rdata;

  logic                    u_in_range;
  logic                    v_in_range;
  logic                    start_ok;
  logic                    slot_free;
  logic [NUM_VERTICES-1:0] cand;
  logic [IDX_W-1:0]        next_w;

  assign u_in_range = ({1'b0, in_vertex_u_i} < VTX_LIMIT);
  assign v_in_range = ({1'b0, in_vertex_v_i} < VTX_LIMIT);
  assign start_ok   = ({1'b0, u_q} < VTX_LIMIT) && present_q[u_q[IDX_W-1:0]];

  // The output register can take a new result when it is empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Neighbors of the current vertex that have not been seen yet.
  assign cand   = row_q & ~visited_q;
  assign next_w = first_set(cand);

  gbfs_ram #(
    .WIDTH(NUM_VERTICES),
    .DEPTH(NUM_VERTICES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  gbfs_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NUM_VERTICES)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  always_comb begin
    state_d      = state_q;
    u_d          = u_q;
    v_d          = v_q;
    key_d        = key_q;
    last_d       = last_q;
    head_d       = head_q;
    tail_d       = tail_q;
    visited_d    = visited_q;
    present_d    = present_q;
    row_valid_d  = row_valid_q;
    row_d        = row_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    out_miss_d   = out_miss_q;
    in_stall_o   = 1'b1;
    adj_we       = 1'b0;
    adj_waddr    = u_q[IDX_W-1:0];
    adj_wdata    = '0;
    adj_raddr    = u_q[IDX_W-1:0];
    q_we         = 1'b0;
    q_waddr      = tail_q[IDX_W-1:0];
    q_wdata      = '0;
    q_raddr      = head_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (in_kind_i)
            KIND_CLEAR: begin
              row_valid_d = '0;
              present_d   = '0;
            end
            KIND_ADD: begin
              // Edges with an end outside the graph are dropped.
              if (u_in_range && v_in_range) begin
                u_d       = in_vertex_u_i;
                v_d       = in_vertex_v_i;
                present_d = present_q | vertex_bit(in_vertex_u_i[IDX_W-1:0])
                                      | vertex_bit(in_vertex_v_i[IDX_W-1:0]);
                state_d   = ST_EDGE_RD;
              end
            end
            KIND_SEARCH: begin
              u_d     = in_vertex_u_i;
              v_d     = in_vertex_v_i;
              state_d = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_EDGE_RD: begin
        state_d = ST_EDGE_WR;
      end

      ST_EDGE_WR: begin
        // A row never written since the last clear reads as empty.
        adj_we      = 1'b1;
        adj_wdata   = (row_valid_q[u_q[IDX_W-1:0]] ? adj_rdata : '0)
                      | vertex_bit(v_q[IDX_W-1:0]);
        row_valid_d = row_valid_q | vertex_bit(u_q[IDX_W-1:0]);
        state_d     = ST_IDLE;
      end

      ST_INIT: begin
        if (!start_ok) begin
          state_d = ST_MISS;
        end else begin
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = u_q[IDX_W-1:0];
          head_d    = '0;
          tail_d    = PTR_W'(1);
          visited_d = '0;
          state_d   = ST_DEQ;
        end
      end

      ST_MISS: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = '0;
          out_last_d   = 1'b1;
          out_miss_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_DEQ: begin
        state_d = ST_KEY;
      end

      ST_KEY: begin
        key_d  = q_rdata;
        head_d = head_q + PTR_W'(1);
        if (VERTEX_W'(q_rdata) == v_q) begin
          // The stop vertex ends the run without scanning its row.
          last_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          last_d    = 1'b0;
          visited_d = visited_q | vertex_bit(q_rdata);
          adj_raddr = q_rdata;
          state_d   = ST_ROW;
        end
      end

      ST_ROW: begin
        row_d   = row_valid_q[key_q] ? adj_rdata : '0;
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (cand == '0) begin
          // The run ends here if nothing is left in the queue.
          last_d  = (head_q == tail_q);
          state_d = ST_EMIT;
        end else begin
          q_we      = 1'b1;
          q_wdata   = next_w;
          tail_d    = tail_q + PTR_W'(1);
          visited_d = visited_q | vertex_bit(next_w);
          row_d     = row_q & ~vertex_bit(next_w);
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VERTEX_W'(key_q);
          out_last_d   = last_q;
          out_miss_d   = 1'b0;
          state_d      = last_q ? ST_IDLE : ST_DEQ;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      present_q   <= '0;
      row_valid_q <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      row_valid_q <= row_valid_d;
      visited_q   <= visited_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q          <= u_d;
    v_q          <= v_d;
    key_q        <= key_d;
    last_q       <= last_d;
    row_q        <= row_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
    out_miss_q   <= out_miss_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_visit_vertex_o  = out_vertex_q;
  assign out_run_last_o      = out_last_q;
  assign out_missing_start_o = out_miss_q;

endmodule

### rtl/gbfs_checker.sv
module gbfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [gbfs_pkg::KIND_W-1:0]   in_kind_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [gbfs_pkg::VERTEX_W-1:0] out_visit_vertex_o,
  input logic                          out_run_last_o,
  input logic                          out_missing_start_o
);

  import gbfs_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_visit_vertex_o) && $stable(out_run_last_o)
      && $stable(out_missing_start_o))
    else $error("stalled result changed");

  // A missing start gives one closing result with vertex zero.
  a_miss_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_missing_start_o |->
      out_run_last_o && (out_visit_vertex_o == '0))
    else $error("missing start result malformed");

  // While a run has results still to come, no new request is taken.
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_run_last_o |-> in_stall_o)
    else $error("request taken in the middle of a search");

  // A search request always keeps the engine busy in the next cycle.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i == KIND_SEARCH) |=> in_stall_o)
    else $error("search request did not occupy the engine");

endmodule

bind graph_breadth_first_search_core gbfs_checker u_gbfs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .in_kind_i          (in_kind_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .out_visit_vertex_o (out_visit_vertex_o),
  .out_run_last_o     (out_run_last_o),
  .out_missing_start_o(out_missing_start_o)
);

### sim/graph_breadth_first_search_core_tb.sv
module graph_breadth_first_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbfs_pkg::*;

  // The block is built at its full size, so every 6-bit vertex number is a
  // legal vertex. The mask still follows the parameter so the graph model
  // stays right if the size is ever reduced.
  localparam int unsigned NV = 64;
  localparam logic [63:0] VERTEX_MASK = (NV >= 64) ? {64{1'b1}} : ((64'd1 << NV) - 64'd1);

  localparam int TOTAL_REQUESTS   = 460;
  // A search visits at most 64 vertices, and the quiet stretch below is long
  // enough for any stray result to show up.
  localparam int SETTLE_CYCLES    = 400;
  localparam int LONG_HOLD_CYCLES = 500;
  // The fourth request code has no meaning; the block drops it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One visit result as it leaves the block.
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
    logic                missing;
  } visit_t;

  // What the sender tells the checker about each request: either a result
  // typed in by hand, or nothing, in which case the graph model predicts it.
  typedef struct packed {
    logic   has_known;
    visit_t known;
  } note_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VERTEX_W-1:0] u;
    logic [VERTEX_W-1:0] v;
    logic                has_known;
    visit_t              known;
  } stim_row_t;

  localparam visit_t MISS_RESULT = {6'd0, 1'b1, 1'b1};
  localparam visit_t NO_RESULT   = {6'd0, 1'b0, 1'b0};

  // Directed requests. Only the searches whose single result is obvious carry
  // a typed result: absent start, stop at start, or a start with no edge out.
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    {KIND_SEARCH, 6'd0,  6'd0,  1'b1, MISS_RESULT},        // empty graph after reset
    {KIND_SEARCH, 6'd63, 6'd63, 1'b1, MISS_RESULT},        // top vertex, still absent
    {KIND_UNUSED, 6'd63, 6'd63, 1'b0, NO_RESULT},          // dropped, no result
    {KIND_ADD,    6'd0,  6'd63, 1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd0,  6'd0,  1'b1, {6'd0, 1'b1, 1'b0}}, // stop is the start
    {KIND_SEARCH, 6'd0,  6'd63, 1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd63, 6'd0,  1'b0, NO_RESULT},          // present, but no way out
    {KIND_ADD,    6'd63, 6'd63, 1'b0, NO_RESULT},          // self-loop
    {KIND_SEARCH, 6'd63, 6'd1,  1'b0, NO_RESULT},
    {KIND_ADD,    6'd63, 6'd0,  1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd0,  6'd5,  1'b0, NO_RESULT},          // stop never reached
    {KIND_ADD,    6'd1,  6'd2,  1'b0, NO_RESULT},
    {KIND_ADD,    6'd1,  6'd3,  1'b0, NO_RESULT},
    {KIND_ADD,    6'd2,  6'd4,  1'b0, NO_RESULT},
    {KIND_ADD,    6'd3,  6'd4,  1'b0, NO_RESULT},          // 4 reached twice
    {KIND_ADD,    6'd4,  6'd1,  1'b0, NO_RESULT},          // cycle back to 1
    {KIND_SEARCH, 6'd1,  6'd4,  1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd1,  6'd63, 1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd5,  6'd5,  1'b1, MISS_RESULT},
    {KIND_CLEAR,  6'd42, 6'd21, 1'b0, NO_RESULT},          // fields are ignored
    {KIND_SEARCH, 6'd0,  6'd0,  1'b1, MISS_RESULT},        // graph is empty again
    {KIND_ADD,    6'd42, 6'd21, 1'b0, NO_RESULT},
    {KIND_SEARCH, 6'd21, 6'd42, 1'b1, {6'd21, 1'b1, 1'b0}},
    {KIND_SEARCH, 6'd42, 6'd21, 1'b0, NO_RESULT},
    {KIND_CLEAR,  6'd0,  6'd0,  1'b0, NO_RESULT}
  };

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid    = 1'b0;
  logic [KIND_W-1:0]   in_kind     = '0;
  logic [VERTEX_W-1:0] in_vertex_u = '0;
  logic [VERTEX_W-1:0] in_vertex_v = '0;
  logic                in_stall;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VERTEX_W-1:0] out_visit_vertex;
  logic                out_run_last;
  logic                out_missing_start;

  // Graph copy kept by the predictor: one adjacency row per vertex and the
  // set of vertices that are ends of some edge.
  logic [63:0] model_rows [64];
  logic [63:0] model_present;

  visit_t pending_visits [$];
  note_t  request_notes [$];

  // When calm is set, neither side inserts gaps, so the block runs back to
  // back for a while. long_hold_req asks the receiver for one long stall.
  bit calm          = 1'b0;
  bit long_hold_req = 1'b0;

  int mismatch_count = 0;
  int sent_count     = 0;
  int search_count   = 0;
  int missing_count  = 0;
  int checked_count  = 0;
  int longest_run    = 0;
  int long_holds     = 0;

  always #6 clk = ~clk;

  graph_breadth_first_search_core #(
    .NUM_VERTICES(NV)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_kind_i          (in_kind),
    .in_vertex_u_i      (in_vertex_u),
    .in_vertex_v_i      (in_vertex_v),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_visit_vertex_o (out_visit_vertex),
    .out_run_last_o     (out_run_last),
    .out_missing_start_o(out_missing_start)
  );

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Gap or stall length for one request or result, zero while calm.
  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Predicts the results of one accepted request and updates the graph copy.
  // A search walks the graph breadth first: a vertex is marked seen when it
  // is queued, neighbors are queued in ascending number, and the run stops
  // once the stop vertex has been emitted or the queue runs dry.
  task automatic predict_visits(input logic [KIND_W-1:0] kind,
                                input logic [VERTEX_W-1:0] start,
                                input logic [VERTEX_W-1:0] stop);
    logic [63:0]         seen;
    logic [63:0]         row;
    logic [VERTEX_W-1:0] fifo [64];
    logic [VERTEX_W-1:0] order [64];
    logic [VERTEX_W-1:0] key;
    visit_t              item;
    int                  head;
    int                  tail;
    int                  produced;
    int                  w;
    case (kind)
      KIND_CLEAR: begin
        for (w = 0; w < 64; w++) model_rows[w] = '0;
        model_present = '0;
      end
      KIND_ADD: begin
        // An edge with an end outside the graph is dropped whole.
        if (VERTEX_MASK[start] && VERTEX_MASK[stop]) begin
          model_rows[start][stop] = 1'b1;
          model_present[start]    = 1'b1;
          model_present[stop]     = 1'b1;
        end
      end
      KIND_SEARCH: begin
        if (!(model_present[start] && VERTEX_MASK[start])) begin
          pending_visits.push_back(MISS_RESULT);
        end else begin
          seen     = '0;
          fifo[0]  = start;
          head     = 0;
          tail     = 1;
          produced = 0;
          while (head != tail && produced < 64) begin
            key = fifo[head];
            head++;
            order[produced] = key;
            produced++;
            if (key == stop) break;
            // The start vertex only gets its mark here, when it leaves the queue.
            seen[key] = 1'b1;
            row = model_rows[key] & VERTEX_MASK;
            for (w = 0; w < 64; w++) begin
              if (row[w] && !seen[w]) begin
                if (tail < 64) begin
                  fifo[tail] = 6'(w);
                  tail++;
                end
                seen[w] = 1'b1;
              end
            end
          end
          for (w = 0; w < produced; w++) begin
            item = {order[w], (w == produced - 1), 1'b0};
            pending_visits.push_back(item);
          end
          if (produced > longest_run) longest_run = produced;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high, so a request that follows with no gap goes out at once.
  task automatic offer(input logic [KIND_W-1:0] kind,
                       input logic [VERTEX_W-1:0] u,
                       input logic [VERTEX_W-1:0] v,
                       input logic has_known,
                       input visit_t known);
    int    gap;
    note_t note;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_vertex_u <= u;
    in_vertex_v <= v;
    note = {has_known, known};
    request_notes.push_back(note);
    do @(posedge clk); while (in_stall !== 1'b0);
    if (kind != KIND_UNUSED) sent_count++;
  endtask

  // The sender holds back until every predicted result has come out, then
  // leaves the block alone long enough for any extra result to appear. The
  // first edge lets the checker predict the request taken at the last edge.
  task automatic drain_results();
    @(posedge clk);
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Checker and predictor share one process. A result taken at an edge can
  // only belong to a request taken at an earlier edge, so checking before
  // predicting keeps the store in order.
  always @(posedge clk) begin : check_and_predict
    visit_t got;
    visit_t want;
    note_t  note;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_visit_vertex, out_run_last, out_missing_start};
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected result: vertex %0d last %b missing %b",
                                  got.vertex, got.last, got.missing));
      end else begin
        want = pending_visits.pop_front();
        if (got.vertex !== want.vertex)
          report_mismatch($sformatf("visit_vertex %0d, expected %0d",
                                    got.vertex, want.vertex));
        if (got.last !== want.last)
          report_mismatch($sformatf("run_last %b, expected %b (vertex %0d)",
                                    got.last, want.last, want.vertex));
        if (got.missing !== want.missing)
          report_mismatch($sformatf("missing_start %b, expected %b (vertex %0d)",
                                    got.missing, want.missing, want.vertex));
        if (want.missing) missing_count++;
        checked_count++;
      end
    end
    if (in_valid === 1'b1 && in_stall === 1'b0) begin
      note = request_notes.pop_front();
      if (in_kind == KIND_SEARCH) search_count++;
      if (note.has_known) pending_visits.push_back(note.known);
      else predict_visits(in_kind, in_vertex_u, in_vertex_v);
    end
  end

  // Receiver: a fresh stall length for every result, or one long hold when
  // the stimulus asks for it, so the engine backs up into its input.
  initial begin : receiver
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD_CYCLES;
        long_holds++;
      end else begin
        n = draw_wait();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [VERTEX_W-1:0] perm [64];
    logic [VERTEX_W-1:0] tmp;
    logic [VERTEX_W-1:0] start;
    logic [VERTEX_W-1:0] stop;
    logic [KIND_W-1:0]   noise_kind;
    int                  i;
    int                  j;
    int                  span;
    int                  base;
    int                  edges;
    int                  searches;
    bit                  chain_done;

    chain_done = 1'b0;
    for (i = 0; i < 64; i++) model_rows[i] = '0;
    model_present = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r])
      offer(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].u, DIRECTED_ROWS[r].v,
            DIRECTED_ROWS[r].has_known, DIRECTED_ROWS[r].known);
    in_valid <= 1'b0;
    drain_results();

    // Random phases: most of them clear the graph, load a handful of edges
    // among a small window of vertices and then search it, with a few dropped
    // or stray requests mixed in as noise.
    while (sent_count < TOTAL_REQUESTS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!chain_done && sent_count >= 200) begin
        // One long chain through all 64 vertices in shuffled order, with a
        // few back edges that never shorten it. A search from its head to its
        // tail gives the most results a run can have. The receiver holds off
        // for a long stretch during it while more searches keep coming.
        chain_done = 1'b1;
        for (i = 0; i < 64; i++) perm[i] = 6'(i);
        for (i = 63; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        offer(KIND_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              1'b0, NO_RESULT);
        for (i = 0; i < 63; i++) offer(KIND_ADD, perm[i], perm[i + 1], 1'b0, NO_RESULT);
        for (i = 0; i < 4; i++) begin
          j = $urandom_range(1, 63);
          offer(KIND_ADD, perm[j], perm[$urandom_range(0, j)], 1'b0, NO_RESULT);
        end
        long_hold_req = 1'b1;
        offer(KIND_SEARCH, perm[0], perm[63], 1'b0, NO_RESULT);
        offer(KIND_SEARCH, perm[0], 6'($urandom_range(0, 63)), 1'b0, NO_RESULT);
        offer(KIND_SEARCH, perm[$urandom_range(0, 63)], perm[63], 1'b0, NO_RESULT);
        in_valid <= 1'b0;
        drain_results();
      end else begin
        if ($urandom_range(0, 3) != 0)
          offer(KIND_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                1'b0, NO_RESULT);
        span  = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(2, 12);
        base  = $urandom_range(0, 64 - span);
        edges = $urandom_range(1, (span <= 12) ? 2 * span : 24);
        for (i = 0; i < edges; i++) begin
          if ($urandom_range(0, 11) == 0) begin
            noise_kind = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : KIND_UNUSED;
            offer(noise_kind, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  1'b0, NO_RESULT);
          end
          offer(KIND_ADD, 6'(base + $urandom_range(0, span - 1)),
                6'(base + $urandom_range(0, span - 1)), 1'b0, NO_RESULT);
        end
        searches = $urandom_range(1, 4);
        for (i = 0; i < searches; i++) begin
          // Mostly start inside the loaded window; now and then anywhere, which
          // often hits an absent vertex. The stop is sometimes off the graph.
          start = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'(base + $urandom_range(0, span - 1));
          stop  = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'(base + $urandom_range(0, span - 1));
          offer(KIND_SEARCH, start, stop, 1'b0, NO_RESULT);
        end
        if ($urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          drain_results();
        end
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    drain_results();

    $display("Run covered %0d requests with %0d searches, %0d results checked,",
             sent_count, search_count, checked_count);
    $display("%0d of them missing-start; longest visit run %0d vertices; %0d long hold(s).",
             missing_count, longest_run, long_holds);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, where every search
  // returns all 64 vertices and every result waits out the longest stall.
  initial begin : watchdog
    #50_000_000;
    $display("Timeout with %0d results still expected.", pending_visits.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
